@@ src/voxel_cube_gradient_macros.svh @@
// assertion macros for the voxel cube gradient block
// included by modules that carry concurrent assertions
`ifndef VOXEL_CUBE_GRADIENT_MACROS_SVH
`define VOXEL_CUBE_GRADIENT_MACROS_SVH
`ifndef ASSERT_OFF
`define VCG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m");
`define VCG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("%m");
`else
`define VCG_ASSERT(label, clk, rst_n, prop)
`define VCG_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ src/vcg_pkg.sv @@
// shared types and constants for the voxel cube gradient block
// no dependencies
`timescale 1ns / 1ps
package vcg_pkg;
  localparam int MAX_SIZE = 64;
  localparam int GRAD_BITS = 42;
  localparam int SIZE_BITS = 7;
  localparam int RECIP_BITS = 24;
  localparam int CORNER_BITS = 3;

  typedef enum logic [2:0] {
    REG_SIZE_X  = 3'd0,
    REG_SIZE_Y  = 3'd1,
    REG_SIZE_Z  = 3'd2,
    REG_RECIP_X = 3'd3,
    REG_RECIP_Y = 3'd4,
    REG_RECIP_Z = 3'd5
  } reg_idx_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CUBE  = 1'b1;

  // corner offsets in marching-cubes order, bit0 x, bit1 y, bit2 z
  function automatic logic [2:0] corner_ofs(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0: r = 3'b000;
      3'd1: r = 3'b001;
      3'd2: r = 3'b011;
      3'd3: r = 3'b010;
      3'd4: r = 3'b100;
      3'd5: r = 3'b101;
      3'd6: r = 3'b111;
      default: r = 3'b110;
    endcase
    return r;
  endfunction
endpackage

@@ src/voxel_cube_gradient.sv @@
// voxel cube gradient top level: volume memory, axis sequencer, shared multiplier
// depends on vcg_pkg and voxel_cube_gradient_macros.svh
//
// usage: in_* carries write and cube transactions, out_* carries gradient
// results, cfg_* is an apb register port (sizes at 0x0..0x8, reciprocal
// spacings at 0xc..0x14).
// a write transaction (func 0) stores one sample at its linear address.
// a cube transaction (func 1) yields eight results, one per corner, the
// eighth with tlast set. each corner is an address step and three axis
// steps; each axis step is two reads of the single-port volume memory, a
// subtract, a multiply and a shift. the axis steps run one after another
// through the single memory port and the shared gradient multiplier.
// in_tready is low while a transaction is worked.
// each result sits in an output register; a stalled receiver holds the
// sequencer at the next corner until the result is taken.
// reset restores sizes of 64 and reciprocals of 1.0; the volume content is
// undefined until written and needs no clearing.
`timescale 1ns / 1ps
`include "voxel_cube_gradient_macros.svh"
module voxel_cube_gradient #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func, sample_addr, sample_value, cell_x, cell_y, cell_z
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // corner, grad_x, grad_y, grad_z
  output logic [135:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int CW    = $clog2(vcg_pkg::MAX_SIZE);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = vcg_pkg::MAX_SIZE * vcg_pkg::MAX_SIZE * vcg_pkg::MAX_SIZE;
  localparam int GB    = vcg_pkg::GRAD_BITS;
  localparam int DW    = SAMPLE_BITS + 1;
  localparam int PW    = DW + vcg_pkg::RECIP_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_ADDR, S_RD_LO, S_RD_UP, S_MUL, S_SCALE, S_OUT
  } state_t;

  state_t state_r;
  logic [6:0] size_x_r, size_y_r, size_z_r;
  logic [23:0] recip_x_r, recip_y_r, recip_z_r;
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r, lo_r;
  logic [AW-1:0] rd_addr;
  logic [2:0] corner_r;
  logic [1:0] axis_r;
  logic [5:0] cx_r, cy_r, cz_r;
  logic [CW-1:0] x_r, y_r, z_r;
  logic [AW-1:0] idx_r, plane_r;
  logic signed [DW-1:0] diff_r;
  logic signed [PW-1:0] prod_r;
  logic central_r;
  logic signed [GB-1:0] gx_r, gy_r, gz_r;
  logic out_valid_r, out_last_r;
  logic [2:0] out_corner_r;
  logic [6:0] nx, ny, nz;

  function automatic logic [6:0] clamp_size(input logic [6:0] v);
    logic [6:0] r;
    if (v < 7'd2) r = 7'd2;
    else if ({25'd0, v} > vcg_pkg::MAX_SIZE) r = 7'(vcg_pkg::MAX_SIZE);
    else r = v;
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_c(input logic [6:0] c, input logic [6:0] n);
    logic [CW-1:0] r;
    if (c > n - 7'd1) r = CW'(n - 7'd1);
    else r = CW'(c);
    return r;
  endfunction

  assign nx = clamp_size(size_x_r);
  assign ny = clamp_size(size_y_r);
  assign nz = clamp_size(size_z_r);

  // cfg port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_comb begin
    unique case (cfg_paddr[4:2])
      vcg_pkg::REG_SIZE_X:  cfg_prdata = {25'd0, size_x_r};
      vcg_pkg::REG_SIZE_Y:  cfg_prdata = {25'd0, size_y_r};
      vcg_pkg::REG_SIZE_Z:  cfg_prdata = {25'd0, size_z_r};
      vcg_pkg::REG_RECIP_X: cfg_prdata = {8'd0, recip_x_r};
      vcg_pkg::REG_RECIP_Y: cfg_prdata = {8'd0, recip_y_r};
      vcg_pkg::REG_RECIP_Z: cfg_prdata = {8'd0, recip_z_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 7'd64; size_y_r <= 7'd64; size_z_r <= 7'd64;
      recip_x_r <= 24'd65536; recip_y_r <= 24'd65536; recip_z_r <= 24'd65536;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      unique case (cfg_paddr[4:2])
        vcg_pkg::REG_SIZE_X:  size_x_r <= cfg_pwdata[6:0];
        vcg_pkg::REG_SIZE_Y:  size_y_r <= cfg_pwdata[6:0];
        vcg_pkg::REG_SIZE_Z:  size_z_r <= cfg_pwdata[6:0];
        vcg_pkg::REG_RECIP_X: recip_x_r <= cfg_pwdata[23:0];
        vcg_pkg::REG_RECIP_Y: recip_y_r <= cfg_pwdata[23:0];
        vcg_pkg::REG_RECIP_Z: recip_z_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // plane stride is registered from the size registers and follows them in the next cycle
  always_ff @(posedge clk) begin
    plane_r <= AW'(nx) * AW'(ny);
  end

  // current axis position and neighbour address
  logic [CW-1:0] c_cur;
  logic [6:0] n_cur;
  logic at_lo, at_hi;
  logic [AW-1:0] stride_cur;
  logic [23:0] recip_cur;
  always_comb begin
    unique case (axis_r)
      2'd0: begin
        c_cur = x_r; n_cur = nx; stride_cur = AW'(1); recip_cur = recip_x_r;
      end
      2'd1: begin
        c_cur = y_r; n_cur = ny; stride_cur = AW'(nx); recip_cur = recip_y_r;
      end
      default: begin
        c_cur = z_r; n_cur = nz; stride_cur = plane_r; recip_cur = recip_z_r;
      end
    endcase
    at_lo = (c_cur == '0);
    at_hi = ({{(7-CW){1'b0}}, c_cur} == n_cur - 7'd1) && !at_lo;
    if (state_r == S_RD_LO) rd_addr = at_lo ? idx_r : idx_r - stride_cur;
    else rd_addr = at_hi ? idx_r : idx_r + stride_cur;
  end

  // volume stored at the linear sample address, one access per cycle
  logic [17:0] waddr;
  logic [AW-1:0] waddr_r;
  logic signed [SAMPLE_BITS-1:0] wval_r;
  logic wmode_r, wbad_r;
  logic wr_en;
  assign waddr = in_tdata[18:1];
  assign wr_en = (state_r == S_SETUP) && wmode_r && !wbad_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr_r] <= wval_r;
    else rd_data_r <= mem[rd_addr];
  end

  assign in_tready = (state_r == S_IDLE);
  logic in_fire, out_fire;
  assign in_fire = in_tvalid & in_tready;
  assign out_fire = out_valid_r & out_tready;

  logic [2:0] ofs;
  assign ofs = vcg_pkg::corner_ofs(corner_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_fire) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          wmode_r <= (in_tdata[0] == vcg_pkg::FUNC_WRITE);
          wbad_r <= ({14'd0, waddr} >= DEPTH);
          waddr_r <= AW'(waddr);
          wval_r <= SAMPLE_BITS'(in_tdata[34:19]);
          cx_r <= in_tdata[40:35]; cy_r <= in_tdata[46:41]; cz_r <= in_tdata[52:47];
          corner_r <= 3'd0;
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          if (wmode_r) begin
            state_r <= S_IDLE;
          end else begin
            x_r <= clamp_c({1'b0, cx_r} + {6'd0, ofs[0]}, nx);
            y_r <= clamp_c({1'b0, cy_r} + {6'd0, ofs[1]}, ny);
            z_r <= clamp_c({1'b0, cz_r} + {6'd0, ofs[2]}, nz);
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          idx_r <= AW'(x_r) + AW'(y_r) * AW'(nx) + AW'(z_r) * plane_r;
          axis_r <= 2'd0;
          state_r <= S_RD_LO;
        end
        S_RD_LO: begin
          central_r <= !at_lo && !at_hi;
          state_r <= S_RD_UP;
        end
        S_RD_UP: begin
          lo_r <= rd_data_r;
          state_r <= S_MUL;
        end
        S_MUL: begin
          diff_r <= DW'(lo_r) - DW'(rd_data_r);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          prod_r <= diff_r * $signed({1'b0, recip_cur});
          state_r <= S_OUT;
        end
        default: begin
          if (!out_valid_r || out_fire) begin
            logic signed [GB-1:0] g;
            g = GB'(central_r ? (prod_r >>> 1) : prod_r);
            unique case (axis_r)
              2'd0: gx_r <= g;
              2'd1: gy_r <= g;
              default: gz_r <= g;
            endcase
            if (axis_r == 2'd2) begin
              out_valid_r <= 1'b1;
              out_corner_r <= corner_r;
              out_last_r <= (corner_r == 3'd7);
              corner_r <= corner_r + 3'd1;
              state_r <= (corner_r == 3'd7) ? S_IDLE : S_SETUP;
            end else begin
              axis_r <= axis_r + 2'd1;
              state_r <= S_RD_LO;
            end
          end
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast = out_last_r;
  assign out_tdata = {7'd0, gz_r, gy_r, gx_r, out_corner_r};

  `VCG_ASSERT_NEXT(a_hold, clk, rst_n, out_valid_r && !out_tready, out_valid_r)
  `VCG_ASSERT(a_busy, clk, rst_n, !(in_tready && state_r != S_IDLE))
  `VCG_ASSERT_NEXT(a_last_idle, clk, rst_n, out_fire && out_last_r && state_r == S_IDLE,
                   !out_valid_r)
endmodule
